// ----- rtl/nearest_five_station_select_defines.svh -----
// assertion macros for the nearest five station select block
// used by the port checker; no dependencies
`ifndef NEAREST_FIVE_STATION_SELECT_DEFINES_SVH
`define NEAREST_FIVE_STATION_SELECT_DEFINES_SVH

// same-cycle implication
`define NFSS_ASSERT_IMPL(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("nfss check failed");

// next-cycle implication
`define NFSS_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("nfss check failed");

`endif

// ----- rtl/nfss_pkg.sv -----
// shared constants and types for the nearest five station select block
// no dependencies; used by every module of the block
package nfss_pkg;

    localparam int NEIGHBORS    = 5;
    localparam int INDEX_BITS   = 12;
    localparam int LAT_W        = 20;
    localparam int LON_W        = 21;
    localparam int IDX_FIELD_W  = 12;
    localparam int DIST_W       = 43;
    localparam int FILL_W       = $clog2(NEIGHBORS + 1);
    localparam int OUT_SLOTS    = 5;
    localparam int OUT_IDX_W    = 12;
    localparam int FILLED_W     = 3;

    localparam int DLAT_W       = LAT_W + 1;
    localparam int DLON_W       = LON_W + 1;
    localparam int SQ_LAT_W     = 2 * DLAT_W;
    localparam int SQ_LON_W     = 2 * DLON_W;

    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 64;
    localparam int IN_LAT_LSB   = 0;
    localparam int IN_LON_LSB   = IN_LAT_LSB + LAT_W;
    localparam int IN_IDX_LSB   = IN_LON_LSB + LON_W;
    localparam int OUT_FILLED_LSB = OUT_SLOTS * OUT_IDX_W;
    localparam int OUT_LAST_SLOT_LSB = (OUT_SLOTS - 1) * OUT_IDX_W;

    typedef enum logic {
        FUNC_QUERY = 1'b0,
        FUNC_CAND  = 1'b1
    } t_func;

    typedef struct packed {
        t_func                    func;
        logic                     last;
        logic signed [LAT_W-1:0]  lat;
        logic signed [LON_W-1:0]  lon;
        logic [INDEX_BITS-1:0]    idx;
    } t_item;

    // travels alongside the distance through the pipe
    typedef struct packed {
        t_func                 func;
        logic                  last;
        logic                  skip;
        logic [INDEX_BITS-1:0] idx;
    } t_tag;

endpackage

// ----- rtl/nearest_five_station_select.sv -----
// a result is valid once the transaction of the last candidate has passed the input register,
// the squares and sum stages and the list; throughput: one transaction per cycle, queries and
// candidates alike, while the result output does not stall; the five parallel distance compares
// and the list shift run together; squares and sum each take a stage of their own ahead of them
// reset: synchronous, active low; empties the pipe, sets the query point to the origin
// with index 0 and empties the list; no clearing pass
module nearest_five_station_select (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // lat [19:0], lon [40:20], station_index [52:41], zero [55:53]
    input  logic [nfss_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // func [0]
    input  logic [0:0]                        i_s_axis_tuser,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // nearest_0 [11:0], nearest_1 [23:12], nearest_2 [35:24], nearest_3 [47:36],
    // nearest_4 [59:48], filled [62:60], zero [63]
    output logic [nfss_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    logic                                r_in_valid;
    nfss_pkg::t_item                     r_in;

    logic                                dist_ready;
    logic                                dist_valid;
    logic [nfss_pkg::DIST_W-1:0]         cand_dist;
    nfss_pkg::t_tag                      dist_tag;
    logic                                list_ready;
    logic                                s_accept;

    assign o_s_axis_tready = !r_in_valid || dist_ready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in.func <= nfss_pkg::t_func'(i_s_axis_tuser[0]);
            r_in.last <= i_s_axis_tlast;
            r_in.lat  <= i_s_axis_tdata[nfss_pkg::IN_LAT_LSB +: nfss_pkg::LAT_W];
            r_in.lon  <= i_s_axis_tdata[nfss_pkg::IN_LON_LSB +: nfss_pkg::LON_W];
            r_in.idx  <= nfss_pkg::INDEX_BITS'(
                i_s_axis_tdata[nfss_pkg::IN_IDX_LSB +: nfss_pkg::IDX_FIELD_W]);
        end
    end

    nfss_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (dist_ready),
        .i_item  (r_in),
        .o_valid (dist_valid),
        .i_ready (list_ready),
        .o_dist  (cand_dist),
        .o_tag   (dist_tag)
    );

    nfss_list u_list (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (dist_valid),
        .o_ready         (list_ready),
        .i_dist          (cand_dist),
        .i_tag           (dist_tag),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// ----- rtl/nfss_dist.sv -----
// squared planar distance pipe: squares stage, then sum stage
// holds the query point; depends on nfss_pkg
module nfss_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  nfss_pkg::t_item             i_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [nfss_pkg::DIST_W-1:0] o_dist,
    output nfss_pkg::t_tag              o_tag
);

    logic signed [nfss_pkg::LAT_W-1:0]      r_q_lat;
    logic signed [nfss_pkg::LON_W-1:0]      r_q_lon;
    logic [nfss_pkg::INDEX_BITS-1:0]        r_q_idx;

    logic                                   r_a_valid;
    logic [nfss_pkg::SQ_LAT_W-1:0]          r_sq_lat;
    logic [nfss_pkg::SQ_LON_W-1:0]          r_sq_lon;
    nfss_pkg::t_tag                         r_a_tag;

    logic                                   r_b_valid;
    logic [nfss_pkg::DIST_W-1:0]            r_dist;
    nfss_pkg::t_tag                         r_b_tag;

    logic signed [nfss_pkg::DLAT_W-1:0]     dlat;
    logic signed [nfss_pkg::DLON_W-1:0]     dlon;
    logic [nfss_pkg::DLAT_W-1:0]            mag_lat;
    logic [nfss_pkg::DLON_W-1:0]            mag_lon;
    logic [nfss_pkg::SQ_LON_W-1:0]          sum_full;
    logic                                   a_ready;
    logic                                   b_ready;
    logic                                   a_load;
    logic                                   b_load;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign a_load  = i_valid && a_ready;
    assign b_load  = r_a_valid && b_ready;
    assign o_ready = a_ready;

    always_comb begin
        dlat    = {r_q_lat[nfss_pkg::LAT_W-1], r_q_lat} - {i_item.lat[nfss_pkg::LAT_W-1], i_item.lat};
        dlon    = {r_q_lon[nfss_pkg::LON_W-1], r_q_lon} - {i_item.lon[nfss_pkg::LON_W-1], i_item.lon};
        // the most negative difference negates to its own pattern, read unsigned it is right
        mag_lat = dlat[nfss_pkg::DLAT_W-1] ? $unsigned(-dlat) : $unsigned(dlat);
        mag_lon = dlon[nfss_pkg::DLON_W-1] ? $unsigned(-dlon) : $unsigned(dlon);
        sum_full = {{(nfss_pkg::SQ_LON_W - nfss_pkg::SQ_LAT_W){1'b0}}, r_sq_lat} + r_sq_lon;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_lat   <= '0;
            r_q_lon   <= '0;
            r_q_idx   <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_load && i_item.func == nfss_pkg::FUNC_QUERY) begin
                r_q_lat <= i_item.lat;
                r_q_lon <= i_item.lon;
                r_q_idx <= i_item.idx;
            end
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_sq_lat      <= {{nfss_pkg::DLAT_W{1'b0}}, mag_lat} * {{nfss_pkg::DLAT_W{1'b0}}, mag_lat};
            r_sq_lon      <= {{nfss_pkg::DLON_W{1'b0}}, mag_lon} * {{nfss_pkg::DLON_W{1'b0}}, mag_lon};
            r_a_tag.func  <= i_item.func;
            r_a_tag.last  <= i_item.last;
            r_a_tag.skip  <= (i_item.idx == r_q_idx);
            r_a_tag.idx   <= i_item.idx;
        end
        if (b_load) begin
            r_dist  <= sum_full[nfss_pkg::DIST_W-1:0];
            r_b_tag <= r_a_tag;
        end
    end

    assign o_valid = r_b_valid;
    assign o_dist  = r_dist;
    assign o_tag   = r_b_tag;

endmodule

// ----- rtl/nfss_list.sv -----
// sorted nearest list with parallel compare and shift insert, plus result register
// depends on nfss_pkg
module nfss_list (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [nfss_pkg::DIST_W-1:0]      i_dist,
    input  nfss_pkg::t_tag                   i_tag,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [nfss_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic [nfss_pkg::DIST_W-1:0]       r_best_dist [nfss_pkg::NEIGHBORS];
    logic [nfss_pkg::INDEX_BITS-1:0]   r_best_idx  [nfss_pkg::NEIGHBORS];
    logic [nfss_pkg::FILL_W-1:0]       r_fill;
    logic                              r_out_valid;
    logic [nfss_pkg::OUT_TDATA_W-1:0]  r_out_data;

    logic [nfss_pkg::DIST_W-1:0]       n_best_dist [nfss_pkg::NEIGHBORS];
    logic [nfss_pkg::INDEX_BITS-1:0]   n_best_idx  [nfss_pkg::NEIGHBORS];
    logic [nfss_pkg::FILL_W-1:0]       n_fill;
    logic [nfss_pkg::OUT_TDATA_W-1:0]  n_out_data;

    logic [nfss_pkg::NEIGHBORS-1:0]    lt;
    logic                              emits;
    logic                              out_free;
    logic                              accept;
    logic                              ins;

    assign emits    = (i_tag.func == nfss_pkg::FUNC_CAND) && i_tag.last;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign o_ready  = !emits || out_free;
    assign accept   = i_valid && o_ready;

    always_comb begin
        for (int k = 0; k < nfss_pkg::NEIGHBORS; k++) begin
            lt[k] = (nfss_pkg::FILL_W'(k) >= r_fill) || (i_dist < r_best_dist[k]);
        end
        // list is sorted, so lt is a thermometer and its top bit says whether anything moves
        ins = (i_tag.func == nfss_pkg::FUNC_CAND) && !i_tag.skip && lt[nfss_pkg::NEIGHBORS-1];

        n_best_dist = r_best_dist;
        n_best_idx  = r_best_idx;
        n_fill      = r_fill;
        if (i_tag.func == nfss_pkg::FUNC_QUERY) begin
            for (int k = 0; k < nfss_pkg::NEIGHBORS; k++) begin
                n_best_dist[k] = '1;
                n_best_idx[k]  = '0;
            end
            n_fill = '0;
        end else if (ins) begin
            if (lt[0]) begin
                n_best_dist[0] = i_dist;
                n_best_idx[0]  = i_tag.idx;
            end
            for (int k = 1; k < nfss_pkg::NEIGHBORS; k++) begin
                if (lt[k]) begin
                    if (lt[k-1]) begin
                        n_best_dist[k] = r_best_dist[k-1];
                        n_best_idx[k]  = r_best_idx[k-1];
                    end else begin
                        n_best_dist[k] = i_dist;
                        n_best_idx[k]  = i_tag.idx;
                    end
                end
            end
            if (r_fill != nfss_pkg::FILL_W'(nfss_pkg::NEIGHBORS)) begin
                n_fill = r_fill + 1'b1;
            end
        end

        n_out_data = '0;
        for (int k = 0; k < nfss_pkg::OUT_SLOTS; k++) begin
            if (k < nfss_pkg::NEIGHBORS && nfss_pkg::FILL_W'(k) < n_fill) begin
                n_out_data[k*nfss_pkg::OUT_IDX_W +: nfss_pkg::OUT_IDX_W] =
                    nfss_pkg::OUT_IDX_W'(n_best_idx[k]);
            end
        end
        if (int'(n_fill) > nfss_pkg::OUT_SLOTS) begin
            n_out_data[nfss_pkg::OUT_FILLED_LSB +: nfss_pkg::FILLED_W] =
                nfss_pkg::FILLED_W'(nfss_pkg::OUT_SLOTS);
        end else begin
            n_out_data[nfss_pkg::OUT_FILLED_LSB +: nfss_pkg::FILLED_W] =
                nfss_pkg::FILLED_W'(n_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill <= n_fill;
            end
            if (accept && emits) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_best_dist <= n_best_dist;
            r_best_idx  <= n_best_idx;
        end
        if (accept && emits) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/nfss_checker.sv -----
// port checker for the nearest five station select block, bound to the top level
// depends on nfss_pkg and nearest_five_station_select_defines.svh
`include "nearest_five_station_select_defines.svh"

module nfss_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_ready,
    input logic                              i_m_valid,
    input logic                              i_m_ready,
    input logic [nfss_pkg::OUT_TDATA_W-1:0]  i_m_data
);

    logic [nfss_pkg::FILLED_W-1:0]   m_filled;
    logic [nfss_pkg::OUT_IDX_W-1:0]  m_far_slot;
    logic                            m_short;

    assign m_filled   = i_m_data[nfss_pkg::OUT_FILLED_LSB +: nfss_pkg::FILLED_W];
    assign m_far_slot = i_m_data[nfss_pkg::OUT_LAST_SLOT_LSB +: nfss_pkg::OUT_IDX_W];
    assign m_short    = (m_filled != nfss_pkg::FILLED_W'(nfss_pkg::OUT_SLOTS));

    // a stalled result transaction stays put
    `NFSS_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, i_m_valid && !i_m_ready, i_m_valid)
    `NFSS_ASSERT_NEXT(a_out_stable, i_clk, !i_rst_n, i_m_valid && !i_m_ready, $stable(i_m_data))
    // short list leaves the farthest slot zero
    `NFSS_ASSERT_IMPL(a_unfilled_zero, i_clk, !i_rst_n, i_m_valid && m_short, m_far_slot == '0)
    // out of reset: nothing pending, input side open
    `NFSS_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b0, !i_rst_n, !i_m_valid && i_s_ready)

endmodule

bind nearest_five_station_select nfss_checker u_nfss_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_ready (o_s_axis_tready),
    .i_m_valid (o_m_axis_tvalid),
    .i_m_ready (i_m_axis_tready),
    .i_m_data  (o_m_axis_tdata)
);

// ----- tb/nearest_list_checker.sv -----
// transaction checker for the nearest five station select block: tracks the
// query point and the sorted candidate list and compares every result list
// depends on nfss_pkg for widths, field positions and the func codes
module nearest_list_checker
    import nfss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [0:0]             i_s_tuser,
    input  logic                   i_s_tlast,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    typedef struct packed {
        logic [FILLED_W-1:0]                  filled;
        logic [OUT_SLOTS-1:0][OUT_IDX_W-1:0]  slot;
    } t_nearest_list;

    logic signed [LAT_W-1:0]  query_lat;
    logic signed [LON_W-1:0]  query_lon;
    logic [INDEX_BITS-1:0]    query_idx;
    logic [DIST_W-1:0]        rank_dist [NEIGHBORS];
    logic [INDEX_BITS-1:0]    rank_idx [NEIGHBORS];
    int                       rank_fill;
    t_nearest_list            expected_lists [$];
    int                       fail_count = 0;
    int                       checked = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;

    task automatic clear_ranking();
        for (int k = 0; k < NEIGHBORS; k++) begin
            rank_dist[k] = '1;
            rank_idx[k]  = '0;
        end
        rank_fill = 0;
    endtask

    task automatic rank_station(input t_func func, input logic last_flag,
                                input logic signed [LAT_W-1:0] lat,
                                input logic signed [LON_W-1:0] lon,
                                input logic [INDEX_BITS-1:0] idx);
        longint            d_lat;
        longint            d_lon;
        logic [DIST_W-1:0] sq_dist;
        int                pos;
        t_nearest_list     lst;
        if (func == FUNC_QUERY) begin
            query_lat = lat;
            query_lon = lon;
            query_idx = idx;
            clear_ranking();
            return;
        end
        if (idx != query_idx) begin
            d_lat   = longint'(query_lat) - longint'(lat);
            d_lon   = longint'(query_lon) - longint'(lon);
            sq_dist = DIST_W'(d_lat * d_lat + d_lon * d_lon);
            // first empty slot or first strictly farther entry, so ties keep order
            pos = NEIGHBORS;
            for (int k = NEIGHBORS - 1; k >= 0; k--) begin
                if (k >= rank_fill || sq_dist < rank_dist[k])
                    pos = k;
            end
            if (pos < NEIGHBORS) begin
                for (int k = NEIGHBORS - 1; k > pos; k--) begin
                    rank_dist[k] = rank_dist[k-1];
                    rank_idx[k]  = rank_idx[k-1];
                end
                rank_dist[pos] = sq_dist;
                rank_idx[pos]  = idx;
                if (rank_fill < NEIGHBORS)
                    rank_fill++;
            end
        end
        if (last_flag) begin
            lst = '0;
            for (int k = 0; k < OUT_SLOTS; k++) begin
                if (k < NEIGHBORS && k < rank_fill)
                    lst.slot[k] = OUT_IDX_W'(rank_idx[k]);
            end
            lst.filled = FILLED_W'((rank_fill > OUT_SLOTS) ? OUT_SLOTS : rank_fill);
            expected_lists.push_back(lst);
        end
    endtask

    task automatic compare_list(input logic [OUT_TDATA_W-1:0] data);
        t_nearest_list        want;
        logic [OUT_IDX_W-1:0] got_idx;
        logic [FILLED_W-1:0]  got_fill;
        if (expected_lists.size() == 0) begin
            $error("result transaction with no list expected, tdata %h", data);
            fail_count++;
            return;
        end
        want = expected_lists.pop_front();
        checked++;
        for (int k = 0; k < OUT_SLOTS; k++) begin
            got_idx = data[k*OUT_IDX_W +: OUT_IDX_W];
            if (got_idx !== want.slot[k]) begin
                $error("nearest_%0d: expected %0d, actual %0d", k, want.slot[k], got_idx);
                fail_count++;
            end
        end
        got_fill = data[OUT_FILLED_LSB +: FILLED_W];
        if (got_fill !== want.filled) begin
            $error("filled: expected %0d, actual %0d", want.filled, got_fill);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            query_lat = '0;
            query_lon = '0;
            query_idx = '0;
            clear_ranking();
            expected_lists.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                rank_station(t_func'(i_s_tuser[0]), i_s_tlast,
                             i_s_tdata[IN_LAT_LSB +: LAT_W],
                             i_s_tdata[IN_LON_LSB +: LON_W],
                             i_s_tdata[IN_IDX_LSB +: INDEX_BITS]);
            if (i_m_tvalid && i_m_tready)
                compare_list(i_m_tdata);
        end
        o_pending = expected_lists.size();
    end

endmodule

// ----- tb/testbench.sv -----
// top of the nearest five station select testbench: clock, reset, stimulus and verdict
// depends on nfss_pkg, the nearest_five_station_select block and nearest_list_checker
module testbench;
    import nfss_pkg::*;

    localparam int LAT_MAX        = 368640;
    localparam int LON_MAX        = 737280;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 800;

    logic                   i_clk;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int checked;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int stall_tick  = 0;

    nearest_five_station_select i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    nearest_list_checker u_list_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver backpressure: switches between free flow, light, heavy and periodic stalls
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready = 1'b1;
            1: m_tready = ($urandom_range(0, 3) != 0);
            2: m_tready = ($urandom_range(0, 3) == 0);
            default: begin
                stall_tick++;
                m_tready = ((stall_tick % 8) >= 5);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int near_coord(input int center, input int span, input int lim);
        int v;
        v = center + int'($urandom_range(0, 2 * span)) - span;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v;
    endfunction

    function automatic int pick_index();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 15);
        return $urandom_range(0, 4095);
    endfunction

    task automatic send_item(input t_func func, input int lat, input int lon,
                             input int idx, input bit last_flag);
        int                    gap;
        logic [IN_TDATA_W-1:0] word;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 14) : $urandom_range(0, 2);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        word = '0;
        word[IN_LAT_LSB +: LAT_W]      = lat[LAT_W-1:0];
        word[IN_LON_LSB +: LON_W]      = lon[LON_W-1:0];
        word[IN_IDX_LSB +: INDEX_BITS] = idx[INDEX_BITS-1:0];
        s_tdata  = word;
        s_tuser  = func;
        s_tlast  = last_flag;
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // one query point followed by its candidates; close_list puts last on the final one
    task automatic run_query(input int n_cand, input bit close_list);
        int q_lat;
        int q_lon;
        int q_idx;
        int c_lat;
        int c_lon;
        int c_idx;
        int span;
        q_lat = near_coord(0, LAT_MAX, LAT_MAX);
        q_lon = near_coord(0, LON_MAX, LON_MAX);
        q_idx = pick_index();
        send_item(FUNC_QUERY, q_lat, q_lon, q_idx, $urandom_range(0, 7) == 0);
        case ($urandom_range(0, 3))
            0: span = 3;
            1: span = 64;
            2: span = 5000;
            default: span = LON_MAX;
        endcase
        c_lat = q_lat;
        c_lon = q_lon;
        for (int k = 0; k < n_cand; k++) begin
            // keeping the previous position now and then gives equal distances
            if ($urandom_range(0, 4) != 0) begin
                c_lat = near_coord(q_lat, span, LAT_MAX);
                c_lon = near_coord(q_lon, span, LON_MAX);
            end
            c_idx = ($urandom_range(0, 11) == 0) ? q_idx : pick_index();
            send_item(FUNC_CAND, c_lat, c_lon, c_idx, close_list && (k == n_cand - 1));
        end
    endtask

    initial begin
        int seq_count;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // candidates before any query use the origin and index 0
        send_item(FUNC_CAND, 5, -5, 0, 1'b0);
        send_item(FUNC_CAND, 100, 200, 9, 1'b0);
        send_item(FUNC_CAND, -1, 1, 4095, 1'b1);
        // last on a query is ignored
        send_item(FUNC_QUERY, LAT_MAX, LON_MAX, 4095, 1'b1);
        send_item(FUNC_CAND, -LAT_MAX, -LON_MAX, 1, 1'b0);
        send_item(FUNC_CAND, LAT_MAX, LON_MAX, 4095, 1'b0);
        send_item(FUNC_CAND, LAT_MAX - 1, LON_MAX, 10, 1'b0);
        send_item(FUNC_CAND, LAT_MAX, LON_MAX - 1, 11, 1'b0);
        send_item(FUNC_CAND, LAT_MAX, LON_MAX, 12, 1'b0);
        send_item(FUNC_CAND, 368000, 737000, 13, 1'b0);
        send_item(FUNC_CAND, LAT_MAX - 2, LON_MAX, 14, 1'b0);
        send_item(FUNC_CAND, 0, 0, 15, 1'b1);
        // list keeps growing after it was sent
        send_item(FUNC_CAND, LAT_MAX, LON_MAX, 0, 1'b1);
        // self match carrying last still sends an empty list
        send_item(FUNC_QUERY, -LAT_MAX, -LON_MAX, 2730, 1'b0);
        send_item(FUNC_CAND, -LAT_MAX, -LON_MAX, 2730, 1'b1);
        send_item(FUNC_QUERY, 12345, -54321, 1365, 1'b0);
        send_item(FUNC_CAND, 12345, -54321, 0, 1'b0);
        send_item(FUNC_CAND, 12345, -54321, 1365, 1'b0);
        send_item(FUNC_CAND, 12346, -54321, 4094, 1'b1);
        wait_drained();

        seq_count = 0;
        while (items_sent < RANDOM_ITEMS + 20) begin
            case ($urandom_range(0, 9))
                0: send_item(($urandom_range(0, 1) == 0) ? FUNC_QUERY : FUNC_CAND,
                             near_coord(0, LAT_MAX, LAT_MAX),
                             near_coord(0, LON_MAX, LON_MAX),
                             $urandom_range(0, 4095), $urandom_range(0, 1) == 1);
                1: run_query($urandom_range(0, 2), 1'b1);
                2: run_query($urandom_range(3, 10), 1'b0);
                default: run_query($urandom_range(3, 14), 1'b1);
            endcase
            if ($urandom_range(0, 9) == 0)
                send_item(FUNC_CAND, near_coord(0, LAT_MAX, LAT_MAX),
                          near_coord(0, LON_MAX, LON_MAX), pick_index(), 1'b1);
            seq_count++;
            if (seq_count == 40)
                wait_drained();
        end
        wait_drained();
        repeat (10) @(negedge i_clk);

        $display("sent %0d input transactions over %0d random sequences, checked %0d lists",
                 items_sent, seq_count, checked);
        $display("covered ties, self matches, short and overfull lists and stalls on both sides");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
